/* rtl/lr_pkg.sv */
// Shared types and constants for the line rasterizer.
`default_nettype none

package lr_pkg;

   localparam int unsigned SCREEN_COLS = 256;

   localparam int unsigned COORD_W = 8;
   localparam int unsigned POS_W   = 9;
   localparam int unsigned ACC_W   = 10;
   localparam int unsigned CH_W    = 5;
   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned WORD_W  = 16;
   localparam int unsigned PROD_W  = 32;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef struct packed {
      op_type              operation;
      logic [COORD_W-1:0]  start_x;
      logic [COORD_W-1:0]  start_y;
      logic [COORD_W-1:0]  end_x;
      logic [COORD_W-1:0]  end_y;
      logic [CH_W-1:0]     red;
      logic [CH_W-1:0]     green;
      logic [CH_W-1:0]     blue;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   pixel_address;
      logic [WORD_W-1:0]   pixel_word;
      logic                last_pixel;
   } rsp_type;

   typedef struct packed {
      logic                x_is_major;
      logic [POS_W-1:0]    major_now;
      logic [POS_W-1:0]    major_end;
      logic [POS_W-1:0]    minor_now;
      logic                minor_down;
      logic [ACC_W-1:0]    remainder_acc;
      logic [POS_W-1:0]    major_span;
      logic [POS_W-1:0]    minor_span;
      logic [WORD_W-1:0]   colour_word;
   } line_type;

endpackage

`default_nettype wire

/* rtl/line_rasterizer.sv */
// Line rasterizer top level: line state, per-pixel stepping and result register.
// A load transfer (operation 0) stores a new line and returns nothing; each
// step transfer (operation 1) returns one framebuffer write (address
// row*SCREEN_COLS+column, pixel word with bit 15 set) until the pixel flagged
// last_pixel, after which steps return nothing until the next load. One item
// is accepted every clock while req_stall is low, and its result appears in
// the result register in the next cycle; the rate is set by the single add,
// compare and subtract of the remainder accumulator. req_stall rises only
// while the result register holds a pixel that the receiver stalls.
`default_nettype none

module line_rasterizer
   import lr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic     active_ff, active_in;
   line_type line_ff, line_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;

   line_type          load_line;
   logic              accept;
   logic              emit;
   logic              last;
   logic [POS_W-1:0]  px;
   logic [POS_W-1:0]  py;
   logic [PROD_W-1:0] addr_full;
   logic [ACC_W-1:0]  acc_sum;
   logic [ACC_W-1:0]  limit;
   line_type          step_line;

   lr_setup u_setup (
      .req  (req_payload),
      .line (load_line)
   );

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign emit      = accept && (req_payload.operation == OP_STEP) && active_ff;

   assign px   = line_ff.x_is_major ? line_ff.major_now : line_ff.minor_now;
   assign py   = line_ff.x_is_major ? line_ff.minor_now : line_ff.major_now;
   assign last = (line_ff.major_now == line_ff.major_end);
   assign addr_full = PROD_W'(py) * PROD_W'(SCREEN_COLS) + PROD_W'(px);

   assign acc_sum = line_ff.remainder_acc + {line_ff.minor_span, 1'b0};
   assign limit   = {line_ff.major_span, 1'b0};

   always_comb begin
      step_line           = line_ff;
      step_line.major_now = line_ff.major_now + POS_W'(1);
      if (acc_sum >= limit) begin
         step_line.remainder_acc = acc_sum - limit;
         if (line_ff.minor_down) begin
            step_line.minor_now = line_ff.minor_now - POS_W'(1);
         end else begin
            step_line.minor_now = line_ff.minor_now + POS_W'(1);
         end
      end else begin
         step_line.remainder_acc = acc_sum;
      end
   end

   always_comb begin
      active_in    = active_ff;
      line_in      = line_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (accept && (req_payload.operation == OP_LOAD)) begin
         active_in = 1'b1;
         line_in   = load_line;
      end
      if (emit) begin
         rsp_valid_in              = 1'b1;
         rsp_in.pixel_address      = addr_full[ADDR_W-1:0];
         rsp_in.pixel_word         = line_ff.colour_word;
         rsp_in.last_pixel         = last;
         if (last) begin
            active_in = 1'b0;
         end else begin
            line_in = step_line;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      line_ff <= line_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

/* rtl/lr_setup.sv */
// Line setup: axis choice, endpoint ordering, spans, initial remainder and colour word.
`default_nettype none

module lr_setup
   import lr_pkg::*;
(
   input  req_type  req,
   output line_type line
);

   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;
   logic               x_major;
   logic [COORD_W-1:0] ma;
   logic [COORD_W-1:0] mb;
   logic [COORD_W-1:0] na;
   logic [COORD_W-1:0] nb;
   logic               swap;
   logic [COORD_W-1:0] lo_major;
   logic [COORD_W-1:0] hi_major;
   logic [COORD_W-1:0] lo_minor;
   logic [COORD_W-1:0] hi_minor;
   logic               down;
   logic [COORD_W-1:0] major_span;
   logic [COORD_W-1:0] minor_span;
   logic [ACC_W-1:0]   acc_init;

   assign dx = (req.start_x > req.end_x) ? req.start_x - req.end_x : req.end_x - req.start_x;
   assign dy = (req.start_y > req.end_y) ? req.start_y - req.end_y : req.end_y - req.start_y;
   assign x_major = (dx >= dy);

   assign ma = x_major ? req.start_x : req.start_y;
   assign na = x_major ? req.start_y : req.start_x;
   assign mb = x_major ? req.end_x   : req.end_y;
   assign nb = x_major ? req.end_y   : req.end_x;

   assign swap     = (ma > mb);
   assign lo_major = swap ? mb : ma;
   assign hi_major = swap ? ma : mb;
   assign lo_minor = swap ? nb : na;
   assign hi_minor = swap ? na : nb;

   assign down       = (hi_minor < lo_minor);
   assign major_span = hi_major - lo_major;
   assign minor_span = down ? lo_minor - hi_minor : hi_minor - lo_minor;

   always_comb begin
      if (major_span == '0) begin
         acc_init = '0;
      end else if (down) begin
         acc_init = ACC_W'(major_span) - ACC_W'(1);
      end else begin
         acc_init = ACC_W'(major_span);
      end
   end

   assign line.x_is_major    = x_major;
   assign line.major_now     = POS_W'(lo_major);
   assign line.major_end     = POS_W'(hi_major);
   assign line.minor_now     = POS_W'(lo_minor);
   assign line.minor_down    = down;
   assign line.remainder_acc = acc_init;
   assign line.major_span    = POS_W'(major_span);
   assign line.minor_span    = POS_W'(minor_span);
   assign line.colour_word   = {1'b1, req.blue, req.green, req.red};

endmodule

`default_nettype wire

/* rtl/lr_checker.sv */
// Port-level checks for the line rasterizer and their binding.
`default_nettype none

module lr_checker
   import lr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.pixel_word[WORD_W-1])
      else $error("pixel word without bit 15");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_payload.operation == OP_LOAD) |=> !rsp_valid)
      else $error("load transfer produced a result");

   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled while result register free");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
